[hdl/trqs_pkg.sv]
// ----------------------------------------------------------------------------
// trqs_pkg
// Shared types and constants for the thread ready queue scheduler: word
// formats, operation and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package trqs_pkg;

  localparam int TS_DEFAULT = 16;
  localparam int ID_W       = 6;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_SCHED  = 2'd2,
    OP_EXIT   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_ID     = 3'd1,
    ST_ABSENT     = 3'd2,
    ST_FULL       = 3'd3,
    ST_ALL_EXITED = 3'd4
  } status_t;

  typedef struct packed {
    op_t               opcode;
    logic signed [7:0] target_thread;
  } trqs_in_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   thread_id;
    logic [ID_W-1:0]   previous_thread;
    logic              switched;
  } trqs_out_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_START,
    CMD_DISPATCH,
    CMD_SCHED_PICK,
    CMD_EXIT_PICK,
    CMD_SCAN,
    CMD_YIELD_HEAD,
    CMD_NODE_TGT,
    CMD_SWITCH,
    CMD_RM0,
    CMD_RM1,
    CMD_RM2,
    CMD_AP0,
    CMD_AP1,
    CMD_PP0,
    CMD_PP1,
    CMD_FINISH
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic id_bad;
    logic absent;
    logic q_empty;
    logic q_one;
    logic cnt_zero;
    logic run_live;
    logic link_null;
    logic cur_free;
    logic scan_wrap;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/trqs_ctrl.sv]
// ----------------------------------------------------------------------------
// trqs_ctrl
// Sequencer for the scheduler: decodes the operation and steps the datapath
// through the free-slot scan and queue remove, append and prepend routines.
// ----------------------------------------------------------------------------
module trqs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  trqs_pkg::dp_stat_t stat,
  output trqs_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCHED_RD,
    S_EXIT_CHK,
    S_SCAN,
    S_YIELD,
    S_YAPP,
    S_YT,
    S_YPRE,
    S_YSW,
    S_RM0,
    S_RM1,
    S_RM2,
    S_AP0,
    S_AP1,
    S_PP0,
    S_PP1,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = trqs_pkg::CMD_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = trqs_pkg::CMD_START;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd = trqs_pkg::CMD_DISPATCH;
        case (stat.op)
          trqs_pkg::OP_CREATE: state_nxt = S_SCAN;
          trqs_pkg::OP_YIELD: begin
            state_nxt = (stat.id_bad || stat.absent) ? S_DONE : S_YIELD;
          end
          trqs_pkg::OP_SCHED: begin
            if (stat.q_empty) begin
              state_nxt = S_DONE;
            end else if (stat.q_one) begin
              state_nxt = S_YIELD;
            end else begin
              state_nxt = S_SCHED_RD;
            end
          end
          default: begin
            // exit: unlink the running thread first if it is still alive
            if (stat.run_live) begin
              state_nxt = S_RM0;
              ret_nxt   = S_EXIT_CHK;
            end else begin
              state_nxt = S_EXIT_CHK;
            end
          end
        endcase
      end
      S_SCHED_RD: begin
        cmd       = trqs_pkg::CMD_SCHED_PICK;
        state_nxt = stat.link_null ? S_DONE : S_YIELD;
      end
      S_EXIT_CHK: begin
        cmd       = trqs_pkg::CMD_EXIT_PICK;
        state_nxt = stat.q_empty ? S_DONE : S_YIELD;
      end
      S_SCAN: begin
        cmd = trqs_pkg::CMD_SCAN;
        if (stat.cur_free) begin
          state_nxt = S_AP0;
          ret_nxt   = S_DONE;
        end else if (stat.scan_wrap) begin
          state_nxt = S_DONE;
        end
      end
      S_YIELD: begin
        cmd = trqs_pkg::CMD_YIELD_HEAD;
        if (stat.q_empty) begin
          state_nxt = S_YT;
        end else begin
          state_nxt = S_RM0;
          ret_nxt   = S_YAPP;
        end
      end
      S_YAPP: begin
        // old head goes back to the tail
        state_nxt = S_AP0;
        ret_nxt   = S_YT;
      end
      S_YT: begin
        cmd       = trqs_pkg::CMD_NODE_TGT;
        state_nxt = S_RM0;
        ret_nxt   = S_YPRE;
      end
      S_YPRE: begin
        state_nxt = S_PP0;
        ret_nxt   = S_YSW;
      end
      S_YSW: begin
        cmd       = trqs_pkg::CMD_SWITCH;
        state_nxt = S_DONE;
      end
      S_RM0: begin
        cmd       = trqs_pkg::CMD_RM0;
        state_nxt = (stat.cnt_zero || stat.q_one) ? ret_r : S_RM1;
      end
      S_RM1: begin
        cmd       = trqs_pkg::CMD_RM1;
        state_nxt = S_RM2;
      end
      S_RM2: begin
        cmd       = trqs_pkg::CMD_RM2;
        state_nxt = ret_r;
      end
      S_AP0: begin
        cmd       = trqs_pkg::CMD_AP0;
        state_nxt = S_AP1;
      end
      S_AP1: begin
        cmd       = trqs_pkg::CMD_AP1;
        state_nxt = ret_r;
      end
      S_PP0: begin
        cmd       = trqs_pkg::CMD_PP0;
        state_nxt = S_PP1;
      end
      S_PP1: begin
        cmd       = trqs_pkg::CMD_PP1;
        state_nxt = ret_r;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd       = trqs_pkg::CMD_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule

[hdl/trqs_dp.sv]
// ----------------------------------------------------------------------------
// trqs_dp
// Scheduler datapath: slot valid bits, queue head/tail/count, cursor,
// running thread, the two link memories and the result register.
// ----------------------------------------------------------------------------
module trqs_dp #(
  parameter int THREAD_SLOTS = trqs_pkg::TS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  trqs_pkg::dp_cmd_t   cmd,
  output trqs_pkg::dp_stat_t  stat,
  input  trqs_pkg::trqs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output trqs_pkg::trqs_out_t out_data
);

  localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int LW = $clog2(THREAD_SLOTS + 1);
  localparam logic [LW-1:0] LNULL     = LW'(THREAD_SLOTS);
  localparam logic [SW-1:0] SLOT_LAST = SW'(THREAD_SLOTS - 1);

  logic [THREAD_SLOTS-1:0] valid_r, valid_nxt;
  logic [LW-1:0]           head_r, head_nxt, tail_r, tail_nxt, count_r, count_nxt;
  logic [SW-1:0]           cursor_r, cursor_nxt, running_r, running_nxt;
  logic [SW-1:0]           start_r, start_nxt, node_r, node_nxt;
  logic [SW-1:0]           tgt_r, tgt_nxt, before_r, before_nxt;
  trqs_pkg::op_t           op_r;
  logic signed [7:0]       tin_r;
  trqs_pkg::status_t       status_r, status_nxt;
  logic                    sw_r, sw_nxt, created_r, created_nxt;

  logic                    out_valid_r;
  trqs_pkg::trqs_out_t     out_data_r;

  // link memories, one write and one read port each
  logic [LW-1:0]           prev_mem [THREAD_SLOTS];
  logic [LW-1:0]           next_mem [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] pv_r, nv_r;
  logic [LW-1:0]           prev_q, next_q;
  logic                    pv_q, nv_q;
  logic                    p_we, n_we;
  logic [SW-1:0]           p_wa, n_wa, p_ra, n_ra;
  logic [LW-1:0]           p_wd, n_wd;

  logic [LW-1:0]           rd_prev, rd_next, node_l;
  logic [SW-1:0]           cur_inc, tin_idx;
  logic                    tgt_ok;

  assign rd_prev = pv_q ? prev_q : LNULL;
  assign rd_next = nv_q ? next_q : LNULL;
  assign node_l  = LW'(node_r);
  assign cur_inc = (cursor_r == SLOT_LAST) ? '0 : cursor_r + 1'b1;
  assign tin_idx = tin_r[SW-1:0];
  assign tgt_ok  = !tin_r[7] && ($unsigned(tin_r) < 8'(THREAD_SLOTS));

  assign p_ra = node_r;
  assign n_ra = (cmd == trqs_pkg::CMD_DISPATCH) ? head_r[SW-1:0] : node_r;

  always_comb begin
    stat.op        = op_r;
    stat.id_bad    = !tgt_ok;
    stat.absent    = !valid_r[tin_idx];
    stat.q_empty   = (count_r == '0) || (head_r >= LNULL);
    stat.q_one     = (count_r == LW'(1));
    stat.cnt_zero  = (count_r == '0);
    stat.run_live  = valid_r[running_r];
    stat.link_null = (rd_next >= LNULL);
    stat.cur_free  = !valid_r[cursor_r];
    stat.scan_wrap = (cur_inc == start_r);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    valid_nxt   = valid_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    cursor_nxt  = cursor_r;
    running_nxt = running_r;
    start_nxt   = start_r;
    node_nxt    = node_r;
    tgt_nxt     = tgt_r;
    before_nxt  = before_r;
    status_nxt  = status_r;
    sw_nxt      = sw_r;
    created_nxt = created_r;
    p_we = 1'b0;
    p_wa = node_r;
    p_wd = LNULL;
    n_we = 1'b0;
    n_wa = node_r;
    n_wd = LNULL;
    case (cmd)
      trqs_pkg::CMD_START: begin
        before_nxt  = running_r;
        status_nxt  = trqs_pkg::ST_OK;
        sw_nxt      = 1'b0;
        created_nxt = 1'b0;
      end
      trqs_pkg::CMD_DISPATCH: begin
        case (op_r)
          trqs_pkg::OP_CREATE: begin
            cursor_nxt = cur_inc;
            start_nxt  = cur_inc;
          end
          trqs_pkg::OP_YIELD: begin
            if (!tgt_ok) begin
              status_nxt = trqs_pkg::ST_BAD_ID;
            end else if (!valid_r[tin_idx]) begin
              status_nxt = trqs_pkg::ST_ABSENT;
            end else begin
              tgt_nxt = tin_idx;
            end
          end
          trqs_pkg::OP_SCHED: begin
            // more than one entry: next_mem[head] is read this cycle
            if ((count_r == '0) || (head_r >= LNULL)) begin
              status_nxt = trqs_pkg::ST_BAD_ID;
            end else if (count_r == LW'(1)) begin
              tgt_nxt = head_r[SW-1:0];
            end
          end
          default: begin
            if (valid_r[running_r]) begin
              valid_nxt[running_r] = 1'b0;
              node_nxt             = running_r;
            end
          end
        endcase
      end
      trqs_pkg::CMD_SCHED_PICK: begin
        if (rd_next >= LNULL) begin
          status_nxt = trqs_pkg::ST_BAD_ID;
        end else begin
          tgt_nxt = rd_next[SW-1:0];
        end
      end
      trqs_pkg::CMD_EXIT_PICK: begin
        if ((count_r == '0) || (head_r >= LNULL)) begin
          status_nxt = trqs_pkg::ST_ALL_EXITED;
        end else begin
          tgt_nxt = head_r[SW-1:0];
        end
      end
      trqs_pkg::CMD_SCAN: begin
        if (!valid_r[cursor_r]) begin
          valid_nxt[cursor_r] = 1'b1;
          created_nxt         = 1'b1;
          node_nxt            = cursor_r;
        end else begin
          cursor_nxt = cur_inc;
          if (cur_inc == start_r) begin
            status_nxt = trqs_pkg::ST_FULL;
          end
        end
      end
      trqs_pkg::CMD_YIELD_HEAD: node_nxt = head_r[SW-1:0];
      trqs_pkg::CMD_NODE_TGT:   node_nxt = tgt_r;
      trqs_pkg::CMD_SWITCH: begin
        sw_nxt      = (running_r != tgt_r);
        running_nxt = tgt_r;
      end
      trqs_pkg::CMD_RM0: begin
        // single entry: empty the queue without reading links
        if (count_r == LW'(1)) begin
          head_nxt  = LNULL;
          tail_nxt  = LNULL;
          p_we      = 1'b1;
          n_we      = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      trqs_pkg::CMD_RM1: begin
        if (head_r == node_l) begin
          head_nxt = rd_next;
          if (rd_next < LNULL) begin
            p_we = 1'b1;
            p_wa = rd_next[SW-1:0];
          end
        end else if (tail_r == node_l) begin
          tail_nxt = rd_prev;
          if (rd_prev < LNULL) begin
            n_we = 1'b1;
            n_wa = rd_prev[SW-1:0];
          end
        end else begin
          if (rd_prev < LNULL) begin
            n_we = 1'b1;
            n_wa = rd_prev[SW-1:0];
            n_wd = rd_next;
          end
          if (rd_next < LNULL) begin
            p_we = 1'b1;
            p_wa = rd_next[SW-1:0];
            p_wd = rd_prev;
          end
        end
      end
      trqs_pkg::CMD_RM2: begin
        p_we      = 1'b1;
        n_we      = 1'b1;
        count_nxt = count_r - 1'b1;
      end
      trqs_pkg::CMD_AP0: begin
        p_we = 1'b1;
        p_wd = tail_r;
        n_we = 1'b1;
      end
      trqs_pkg::CMD_AP1: begin
        if ((count_r != '0) && (tail_r < LNULL)) begin
          n_we = 1'b1;
          n_wa = tail_r[SW-1:0];
          n_wd = node_l;
        end else begin
          head_nxt = node_l;
        end
        tail_nxt  = node_l;
        count_nxt = count_r + 1'b1;
      end
      trqs_pkg::CMD_PP0: begin
        p_we = 1'b1;
        n_we = 1'b1;
        n_wd = head_r;
      end
      trqs_pkg::CMD_PP1: begin
        if ((count_r != '0) && (head_r < LNULL)) begin
          p_we = 1'b1;
          p_wa = head_r[SW-1:0];
          p_wd = node_l;
        end else begin
          tail_nxt = node_l;
        end
        head_nxt  = node_l;
        count_nxt = count_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= THREAD_SLOTS'(1);
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= LW'(1);
      cursor_r    <= '0;
      running_r   <= '0;
      pv_r        <= '0;
      nv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      cursor_r  <= cursor_nxt;
      running_r <= running_nxt;
      if (p_we) begin
        pv_r[p_wa] <= 1'b1;
      end
      if (n_we) begin
        nv_r[n_wa] <= 1'b1;
      end
      if (cmd == trqs_pkg::CMD_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r   <= start_nxt;
    node_r    <= node_nxt;
    tgt_r     <= tgt_nxt;
    before_r  <= before_nxt;
    status_r  <= status_nxt;
    sw_r      <= sw_nxt;
    created_r <= created_nxt;
    pv_q      <= pv_r[p_ra];
    nv_q      <= nv_r[n_ra];
    if (cmd == trqs_pkg::CMD_START) begin
      op_r  <= in_data.opcode;
      tin_r <= in_data.target_thread;
    end
    if (cmd == trqs_pkg::CMD_FINISH) begin
      out_data_r.status          <= status_r;
      out_data_r.thread_id       <= trqs_pkg::ID_W'(created_r ? cursor_r : running_r);
      out_data_r.previous_thread <= trqs_pkg::ID_W'(before_r);
      out_data_r.switched        <= sw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      prev_mem[p_wa] <= p_wd;
    end
    if (n_we) begin
      next_mem[n_wa] <= n_wd;
    end
    prev_q <= prev_mem[p_ra];
    next_q <= next_mem[n_ra];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/thread_ready_queue_scheduler.sv]
// ----------------------------------------------------------------------------
// thread_ready_queue_scheduler
// Round-robin thread scheduler with a slot table and a doubly linked
// ready queue; create, yield, schedule-next and exit operations.
// ----------------------------------------------------------------------------
// One word is taken at a time and gives exactly one result word. The time
// per word is set by the sequencer walking the doubly linked ready queue
// through two link memories (prev and next), each with one read and one
// write port. A remove steps through RM0, RM1 and RM2, or stops after RM0
// while the queue holds a single entry; an append steps through AP0 and
// AP1 and a prepend through PP0 and PP1. A rejected yield or sched
// finishes without touching the queue. Yield, sched and exit are built
// from these routines, and a create steps the round-robin cursor one
// slot per cycle until it finds a free slot or the table proves full. A
// new word is accepted as soon as the previous result has been loaded
// into the output register, even while that result is still stalled.
// No clearing pass is needed after reset.
module thread_ready_queue_scheduler #(
  parameter int THREAD_SLOTS = trqs_pkg::TS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  trqs_pkg::trqs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output trqs_pkg::trqs_out_t out_data
);

  trqs_pkg::dp_cmd_t  cmd;
  trqs_pkg::dp_stat_t stat;

  trqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  trqs_dp #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hdl/trqs_checker.sv]
// ----------------------------------------------------------------------------
// trqs_checker
// Port-level checks for the thread ready queue scheduler, bound to the top.
// ----------------------------------------------------------------------------
module trqs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input trqs_pkg::trqs_out_t out_data
);

  // one word in flight: the block is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("word accepted while block still idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.switched |->
      (out_data.status == trqs_pkg::ST_OK) &&
      (out_data.thread_id != out_data.previous_thread))
    else $error("switch reported without a change of running thread");

  a_error_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != trqs_pkg::ST_OK) |-> !out_data.switched)
    else $error("failed operation reported a switch");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind thread_ready_queue_scheduler trqs_checker u_trqs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
